// ===== src/wbps_pkg.sv =====
// wbps_pkg: shared types and constants for the wildcard byte pattern scanner
// no dependencies
package wbps_pkg;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_IMAGE = 1'b1;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_CAP_OFF = 2'd1,
        KIND_CAP_VAL = 2'd2
    } kind_t;

    localparam logic [1:0] ADDR_LENGTH = 2'd0;
    localparam logic [1:0] ADDR_BEGIN  = 2'd1;
    localparam logic [1:0] ADDR_END    = 2'd2;

    // one pattern table entry
    typedef struct packed {
        logic [3:0] size;
        logic       cap;
        logic       wild;
        logic [7:0] value;
    } pat_entry_t;

    // per-cell control from the top
    typedef struct packed {
        logic       shift;
        logic       load;
        logic [7:0] in_byte;
    } cell_ctrl_t;

endpackage

// ===== src/wildcard_byte_pattern_scanner.sv =====
// wildcard_byte_pattern_scanner: top level, cell chain, report sequencer, apb regs
// depends on wbps_pkg and wbps_cell
//
// Load pattern entries (tuser=0) then stream image bytes (tuser=1, tlast on the final
// byte), one per cycle while no report is being sent. A chain of MAX_PATTERN cells holds
// the byte window and the pattern and compares all entries in the cycle a byte arrives.
// On a match the window stays frozen and the report is emitted from it by the report
// sequencer, one pattern entry examined per cycle, a capture only while the result side
// accepts (a value capture skips the entries it covers). Input is stalled after the
// matching byte through the start, the walk over the entries, the repeated start when
// there is no capture and the finish, and while the result side holds off. Without a
// match image bytes are taken one per cycle, as long as the single result register is free.
module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN       = 32,
    parameter int MAX_CAPTURE_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: entry_index[4:0], entry_byte[12:5], entry_wildcard[13], entry_capture[14],
    //        entry_capture_size[18:15], image_byte[26:19], zero[31:27]
    input  logic [31:0] s_tdata,
    // tuser: req_type
    input  logic        s_tuser,
    // tlast: image_last
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: entry_value[63:0]
    output logic [63:0] m_tdata,
    // tuser: found[0], entry_kind[2:1]
    output logic [2:0]  m_tuser,
    // tlast: last_entry
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);

    // ---------------- configuration
    logic [5:0]  plen_reg;
    logic [31:0] rbeg_reg, rend_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= '0;
            rbeg_reg <= '0;
            rend_reg <= '1;
        end else if (wr) begin
            case (paddr[3:2])
                ADDR_LENGTH: plen_reg <= pwdata[5:0];
                ADDR_BEGIN:  rbeg_reg <= pwdata;
                ADDR_END:    rend_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            ADDR_LENGTH: prdata = {26'd0, plen_reg};
            ADDR_BEGIN:  prdata = rbeg_reg;
            ADDR_END:    prdata = rend_reg;
            default:     prdata = '0;
        endcase
    end

    logic [LW-1:0] len;
    assign len = ({26'd0, plen_reg} > 32'(MAX_PATTERN)) ? LW'(MAX_PATTERN)
                                                         : LW'(plen_reg);

    // ---------------- input decode
    logic       is_img, is_load, s_acc;
    logic [4:0] f_idx;
    logic [7:0] f_img;
    logic       f_last;
    pat_entry_t f_entry;

    assign f_idx   = s_tdata[4:0];
    assign f_entry = '{size: s_tdata[18:15], cap: s_tdata[14], wild: s_tdata[13],
                       value: s_tdata[12:5]};
    assign f_img   = s_tdata[26:19];
    assign f_last  = s_tlast;
    assign s_acc   = s_tvalid && s_tready;
    assign is_img  = s_acc && (s_tuser == REQ_IMAGE);
    assign is_load = s_acc && (s_tuser == REQ_LOAD);

    // ---------------- cell chain
    cell_ctrl_t ctrl;
    logic [7:0] win   [MAX_PATTERN];
    logic [7:0] align [MAX_PATTERN];
    pat_entry_t ent   [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hit;

    assign ctrl = '{shift: is_img, load: is_load, in_byte: f_img};

    // window after shift: post[i] = win[i+1], post[MAX-1] = new byte
    logic [7:0] post [MAX_PATTERN];
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        if (i == MAX_PATTERN - 1) begin : g_end
            assign post[i] = ctrl.in_byte;
        end else begin : g_mid
            assign post[i] = win[i+1];
        end
        // entry j compares against post[MAX-len+j]
        always_comb begin
            align[i] = 8'd0;
            for (int k = 0; k < MAX_PATTERN; k++) begin
                if (LW'(k) == LW'(i) + LW'(MAX_PATTERN) - len) align[i] = post[k];
            end
        end
        wbps_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .sel        ({27'd0, f_idx} == 32'(i)),
            .load_entry (f_entry),
            .prev_byte  (post[i]),
            .align_byte (align[i]),
            .win_byte   (win[i]),
            .entry      (ent[i]),
            .hit        (hit[i])
        );
    end

    logic all_hit;
    always_comb begin
        all_hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (LW'(i) < len && !hit[i]) all_hit = 1'b0;
        end
    end

    // ---------------- offset and range
    logic [31:0] off_reg;
    logic        done_reg;
    logic [32:0] o1, s33, send;
    logic        cand;

    assign o1   = {1'b0, off_reg} + 33'd1;
    assign s33  = o1 - {{(33-LW){1'b0}}, len};
    assign send = o1;
    assign cand = (len != '0) && (o1 >= {{(33-LW){1'b0}}, len})
               && (s33 >= {1'b0, rbeg_reg}) && (send <= {1'b0, rend_reg})
               && all_hit && !done_reg;

    // ---------------- report sequencer
    typedef enum logic [1:0] {ST_IDLE, ST_START, ST_WALK, ST_NF} state_t;
    state_t       state_reg;
    logic [LW-1:0] slen_reg;
    logic [LW-1:0] j_reg;
    logic [31:0]  s_reg;
    logic         last_pend_reg;   // image_last came with the matching byte
    logic         ov_reg;          // output register valid
    logic         of_reg;
    logic [1:0]   ok_reg;
    logic [63:0]  ov_val_reg;
    logic         ol_reg;

    logic out_free;
    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;

    // walk: the window is frozen while a report is out, so it is read directly
    logic [IW-1:0]  jj;
    logic [IW-1:0]  wbase;
    pat_entry_t     je;
    logic [LW-1:0]  csz;
    logic [63:0]    cval;
    logic [LW-1:0]  rem;
    logic [LW-1:0]  nj;
    logic           more_cap;
    assign jj    = j_reg[IW-1:0];
    assign je    = ent[jj];
    assign rem   = slen_reg - j_reg;
    assign wbase = IW'(LW'(MAX_PATTERN) - slen_reg);
    always_comb begin
        csz = ({{(LW > 4 ? LW-4 : 0){1'b0}}, je.size} > LW'(MAX_CAPTURE_BYTES))
              ? LW'(MAX_CAPTURE_BYTES) : LW'(je.size);
        if (csz > rem) csz = rem;
        cval = '0;
        for (int k = 0; k < MAX_CAPTURE_BYTES; k++) begin
            if (LW'(k) < csz) cval[8*k +: 8] = win[wbase + jj + IW'(k)];
        end
        nj = (je.size == 4'd0) ? j_reg + LW'(1) : j_reg + csz;
        // any capture left after this one closes the report later
        more_cap = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (ent[i].cap && LW'(i) >= nj && LW'(i) < slen_reg) more_cap = 1'b1;
        end
    end
    logic walk_end;
    assign walk_end = (j_reg >= slen_reg);

    always_ff @(posedge aclk) begin
        if (is_img && cand) begin
            slen_reg <= len;
            s_reg    <= s33[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            off_reg       <= '0;
            done_reg      <= 1'b0;
            ov_reg        <= 1'b0;
            of_reg        <= 1'b0;
            ok_reg        <= KIND_START;
            ov_val_reg    <= '0;
            ol_reg        <= 1'b0;
            j_reg         <= '0;
            last_pend_reg <= 1'b0;
        end else begin
            if (ov_reg && m_tready) ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (is_img) begin
                        if (off_reg != '1) off_reg <= off_reg + 32'd1;
                        if (cand) begin
                            done_reg      <= 1'b1;
                            state_reg     <= ST_START;
                            last_pend_reg <= f_last;
                        end else if (f_last) begin
                            off_reg <= '0;
                            if (!done_reg) begin
                                ov_reg     <= 1'b1;
                                of_reg     <= 1'b0;
                                ok_reg     <= KIND_START;
                                ov_val_reg <= '0;
                                ol_reg     <= 1'b1;
                            end
                            done_reg <= 1'b0;
                        end
                    end
                end
                ST_START: begin
                    if (out_free) begin
                        ov_reg     <= 1'b1;
                        of_reg     <= 1'b1;
                        ok_reg     <= KIND_START;
                        ov_val_reg <= {32'd0, s_reg};
                        ol_reg     <= 1'b0;
                        j_reg      <= '0;
                        state_reg  <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (walk_end) begin
                        // no capture in the pattern: start offset goes out again
                        if (out_free) begin
                            ov_reg     <= 1'b1;
                            of_reg     <= 1'b1;
                            ok_reg     <= KIND_START;
                            ov_val_reg <= {32'd0, s_reg};
                            ol_reg     <= 1'b1;
                            state_reg  <= ST_NF;
                        end
                    end else if (!je.cap) begin
                        j_reg <= j_reg + LW'(1);
                    end else if (out_free) begin
                        ov_reg <= 1'b1;
                        of_reg <= 1'b1;
                        if (je.size == 4'd0) begin
                            ok_reg     <= KIND_CAP_OFF;
                            ov_val_reg <= {32'd0, s_reg} + {{(64-LW){1'b0}}, j_reg};
                        end else begin
                            ok_reg     <= KIND_CAP_VAL;
                            ov_val_reg <= cval;
                        end
                        j_reg  <= nj;
                        ol_reg <= !more_cap;
                        if (!more_cap) state_reg <= ST_NF;
                    end
                end
                default: begin
                    // ST_NF: report closing; wait for output then finish
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                        if (last_pend_reg) begin
                            off_reg  <= '0;
                            done_reg <= 1'b0;
                        end
                        last_pend_reg <= 1'b0;
                    end
                end
            endcase
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = ov_val_reg;
    assign m_tuser  = {ok_reg, of_reg};
    assign m_tlast  = ol_reg;

endmodule

// ===== src/wbps_cell.sv =====
// wbps_cell: one window byte and one pattern entry with its compare
// depends on wbps_pkg
module wbps_cell
    import wbps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic       sel,
    input  pat_entry_t load_entry,
    input  logic [7:0] prev_byte,
    input  logic [7:0] align_byte,
    output logic [7:0] win_byte,
    output pat_entry_t entry,
    output logic       hit
);

    logic [7:0] win_reg;
    pat_entry_t entry_reg;

    // window shifts toward cell 0, new byte enters at the far end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (ctrl.shift) begin
            win_reg <= prev_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load && sel) begin
            entry_reg <= load_entry;
        end
    end

    assign win_byte = win_reg;
    assign entry    = entry_reg;
    assign hit      = entry_reg.wild || (entry_reg.value == align_byte);

endmodule

// ===== src/wbps_checker.sv =====
// wbps_checker: port-level assertions for the scanner, bound to the top level
// depends on wbps_pkg
module wbps_checker
    import wbps_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast,
    input logic        pready
);

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_nf_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == '0)
                                    && (m_tuser[2:1] == KIND_START))
        else $error("not-found report malformed");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[2:1] <= KIND_CAP_VAL)
        else $error("bad kind");

    // a waiting result blocks new input
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input open while result stalled");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast), .pready(pready)
);

// ===== sim/wildcard_byte_pattern_scanner_test.sv =====
// testbench for wildcard_byte_pattern_scanner: pattern loads and image streams,
// APB register setup, checks every report against a predictor built into a scoreboard
// depends on wbps_pkg and the scanner RTL
module wildcard_byte_pattern_scanner_test;
    import wbps_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int CAP_MAX     = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic        found;
        logic [1:0]  kind;
        logic [63:0] value;
        logic        last;
    } report_t;

    class scan_scoreboard;
        logic [7:0]  pat_byte [TABLE_DEPTH];
        logic        pat_wild [TABLE_DEPTH];
        logic        pat_cap  [TABLE_DEPTH];
        logic [3:0]  pat_size [TABLE_DEPTH];
        logic [7:0]  window   [TABLE_DEPTH];
        logic [31:0] offset;
        logic        matched;
        logic [5:0]  length;
        logic [31:0] rbegin;
        logic [31:0] rend;
        report_t     pending[$];
        int          errors;

        function void clear();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                pat_byte[i] = '0; pat_wild[i] = '0; pat_cap[i] = '0; pat_size[i] = '0;
                window[i] = '0;
            end
            offset = '0; matched = '0; length = '0; rbegin = '0; rend = 32'hFFFF_FFFF;
            errors = 0;
        endfunction

        function void push(logic f, logic [1:0] k, logic [63:0] v, logic l);
            report_t r;
            r.found = f; r.kind = k; r.value = v; r.last = l;
            pending = {pending, r};
        endfunction

        // candidate ending at offset o; returns 1 and queues the report on a hit
        function bit try_match(logic [32:0] o);
            int len, base, sz, n;
            logic [32:0] s;
            logic [63:0] v;
            len = (length > TABLE_DEPTH) ? TABLE_DEPTH : length;
            if (len == 0 || o + 1 < len) return 0;
            s = o + 1 - len;
            if (s < {1'b0, rbegin} || s + len > {1'b0, rend}) return 0;
            base = TABLE_DEPTH - len;
            for (int j = 0; j < len; j++)
                if (!pat_wild[j] && window[base + j] != pat_byte[j]) return 0;
            push(1'b1, KIND_START, 64'(s), 1'b0);
            n = 1;
            for (int j = 0; j < len; j++) begin
                if (!pat_cap[j]) continue;
                sz = pat_size[j];
                if (sz == 0) begin
                    push(1'b1, KIND_CAP_OFF, 64'(s + j), 1'b0);
                end else begin
                    if (sz > CAP_MAX) sz = CAP_MAX;
                    if (sz > len - j) sz = len - j;
                    v = '0;
                    for (int k = 0; k < sz; k++) v |= 64'(window[base + j + k]) << (8 * k);
                    push(1'b1, KIND_CAP_VAL, v, 1'b0);
                    j += sz - 1;
                end
                n++;
            end
            if (n < 2) push(1'b1, KIND_START, 64'(s), 1'b0);
            pending[pending.size() - 1].last = 1'b1;
            return 1;
        endfunction

        function void note_input(logic req, logic [31:0] d, logic last);
            logic [31:0] o;
            if (req == REQ_LOAD) begin
                pat_byte[d[4:0]] = d[12:5];
                pat_wild[d[4:0]] = d[13];
                pat_cap[d[4:0]]  = d[14];
                pat_size[d[4:0]] = d[18:15];
                return;
            end
            o = offset;
            for (int i = 0; i < TABLE_DEPTH - 1; i++) window[i] = window[i + 1];
            window[TABLE_DEPTH - 1] = d[26:19];
            if (offset != 32'hFFFF_FFFF) offset++;
            if (!matched && try_match({1'b0, o})) matched = 1'b1;
            if (last) begin
                if (!matched) push(1'b0, KIND_START, 64'd0, 1'b1);
                offset = '0;
                matched = 1'b0;
            end
        endfunction

        function void check_result(logic [63:0] d, logic [2:0] u, logic l);
            report_t e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result: expected none, actual found=%0b kind=%0d value=%h last=%0b",
                         $time, u[0], u[2:1], d, l);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (u[0] !== e.found || u[2:1] !== e.kind || d !== e.value || l !== e.last) begin
                $display("%0t result mismatch: expected found=%0b kind=%0d value=%h last=%0b",
                         $time, e.found, e.kind, e.value, e.last);
                $display("%0t                  actual   found=%0b kind=%0d value=%h last=%0b",
                         $time, u[0], u[2:1], d, l);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = 0;
    logic        s_tuser = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    scan_scoreboard board = new();
    int  cycles = 0;
    bit  hold_off = 0;
    bit  offering = 0;
    int  burst_left = 0;
    logic [7:0] sig [TABLE_DEPTH];

    wildcard_byte_pattern_scanner DUT (.*);

    initial forever #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stall pattern, long hold-off on request
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser, m_tlast);
        if (hold_off) m_tready <= 0;
        else m_tready <= ($urandom_range(0, 3) != 0) || (cycles % 200 < 40);
    end

    task automatic reg_write(logic [1:0] a, logic [31:0] v);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {a, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (a)
            ADDR_LENGTH: board.length = v[5:0];
            ADDR_BEGIN:  board.rbegin = v;
            default:     board.rend = v;
        endcase
    endtask

    task automatic send(logic req, logic [31:0] d, logic last);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 4)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1; s_tuser <= req; s_tdata <= d; s_tlast <= last;
        offering = 1;
        do @(posedge aclk); while (!s_tready);
        board.note_input(req, d, last);
        if (burst_left == 0 || $urandom_range(0, 9) == 0) begin
            s_tvalid <= 0;
            offering = 0;
            if (burst_left != 0) @(posedge aclk);
        end
    endtask

    task automatic load_entry(int idx, logic [7:0] b, bit w, bit c, logic [3:0] sz);
        send(REQ_LOAD, {13'd0, sz, c, w, b, 5'(idx)}, 1'($urandom));
    endtask

    task automatic image_byte(logic [7:0] b, bit last);
        send(REQ_IMAGE, {5'd0, b, 19'($urandom)}, last);
    endtask

    task automatic drain();
        if (offering) begin
            s_tvalid <= 0;
            offering = 0;
        end
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // fresh signature of given length; every entry written before use
    task automatic new_pattern(int len);
        for (int i = 0; i < len; i++) begin
            sig[i] = 8'($urandom);
            load_entry(i, sig[i], $urandom_range(0, 4) == 0, $urandom_range(0, 3) == 0,
                       4'($urandom_range(0, 15)));
        end
    endtask

    // image with the signature planted at a random spot (or not)
    task automatic planted_image(int len, int size);
        int at;
        at = $urandom_range(0, size);
        for (int i = 0; i < size; i++) begin
            if (i >= at && i - at < len && $urandom_range(0, 5) != 0) image_byte(sig[i - at], i == size - 1);
            else image_byte(8'($urandom), i == size - 1);
        end
    endtask

    initial begin
        int len;
        board.clear();
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        // directed: full-width entries, extreme bytes, captures of every kind
        reg_write(ADDR_LENGTH, 4);
        load_entry(0, 8'hFF, 1'b0, 1'b1, 4'd0);
        load_entry(1, 8'h00, 1'b1, 1'b1, 4'd15);
        load_entry(2, 8'h00, 1'b1, 1'b0, 4'd0);
        load_entry(3, 8'hAA, 1'b0, 1'b1, 4'd2);
        load_entry(31, 8'h55, 1'b1, 1'b1, 4'd8);
        image_byte(8'h00, 1'b0); image_byte(8'hFF, 1'b0); image_byte(8'h12, 1'b0);
        image_byte(8'h34, 1'b0); image_byte(8'hAA, 1'b0); image_byte(8'hFF, 1'b1);
        image_byte(8'hFF, 1'b0); image_byte(8'h01, 1'b1);
        image_byte(8'hFF, 1'b0); image_byte(8'h1, 1'b0); image_byte(8'h2, 1'b0);
        image_byte(8'hAA, 1'b1);
        drain();
        reg_write(ADDR_LENGTH, 1);
        image_byte(8'hFF, 1'b1);
        image_byte(8'h00, 1'b1);
        drain();
        reg_write(ADDR_LENGTH, 0);
        image_byte(8'hFF, 1'b1);
        drain();
        // saturated length: all 32 entries in use, uncaptured
        reg_write(ADDR_LENGTH, 63);
        for (int i = 0; i < TABLE_DEPTH; i++) load_entry(i, 8'd0, 1'b1, 1'b0, 4'd0);
        for (int i = 0; i < 33; i++) image_byte(8'($urandom), i == 32);
        drain();
        // random phases over range and length settings
        for (int ph = 0; ph < 6; ph++) begin
            len = (ph % 4 == 3) ? $urandom_range(20, 32) : $urandom_range(1, 6);
            reg_write(ADDR_LENGTH, len);
            reg_write(ADDR_BEGIN, (ph % 3 == 0) ? 0 : $urandom_range(0, 6));
            reg_write(ADDR_END, (ph % 3 == 1) ? 32'hFFFF_FFFF : $urandom_range(len, 40));
            new_pattern(len);
            if (ph == 5) fork
                begin hold_off = 1; repeat (300) @(posedge aclk); hold_off = 0; end
            join_none
            for (int k = 0; k < 3; k++) planted_image(len, $urandom_range(len, len + 8));
            drain();
        end
        reg_write(ADDR_BEGIN, 32'hFFFF_FFFF);
        reg_write(ADDR_END, 0);
        image_byte(8'h00, 1'b1);
        drain();
        if (board.errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
